### sv/swmm_pkg.sv
// Shared types and constants of the sliding window min/max block.
// Used by the core, the tracker and the testbench; depends on nothing.
package swmm_pkg;

  localparam int TIME_BITS      = 48;
  localparam int SAMPLE_BITS    = 16;
  localparam int WLEN_BITS      = 7;
  localparam int CFG_INDEX_BITS = 4;
  localparam int CFG_DATA_BITS  = 7;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW_LEN   = 4'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DUAL_CHANNEL = 4'd1;

  // Window length reset value, shortest window and chart ready threshold
  localparam logic [WLEN_BITS-1:0] WLEN_RESET  = 7'd64;
  localparam int                   WLEN_MIN    = 3;
  localparam int                   READY_ABOVE = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] timestamp;
    sample_t              sample_a;
    sample_t              sample_b;
  } in_item_t;

  typedef struct packed {
    sample_t              min_a;
    sample_t              max_a;
    sample_t              min_b;
    sample_t              max_b;
    logic [TIME_BITS-1:0] oldest_time;
    logic [TIME_BITS-1:0] newest_time;
    logic [WLEN_BITS-1:0] fill_count;
    logic                 chart_ready;
  } out_item_t;

  // Operations on one extreme tracker
  typedef enum logic [2:0] {
    TRK_HOLD,
    TRK_RESTART,    // position back to zero, no rescan pending
    TRK_LOAD,       // take the candidate unconditionally
    TRK_BETTER,     // take the candidate if strictly better
    TRK_SLIDE,      // window slides: mark stale if evicted, else as TRK_BETTER
    TRK_SCAN_FIRST, // first entry of a rescan, taken if stale
    TRK_SCAN_NEXT,  // later rescan entry, taken if stale and strictly better
    TRK_SETTLE      // rescan finished
  } trk_op_t;

endpackage

### sv/sliding_window_min_max_core.sv
// Sliding window min/max of two signed Q8.8 channels over the last window_len
// beats. The points sit in a ring buffer in one RAM with a registered read;
// min and max of each channel are held as cached value and slot. A beat is
// accepted when the block is idle. While the window fills, a beat goes from
// idle straight to the finish state. Once the window is full, a beat that
// leaves every tracked extreme in the window passes the scan state, where
// one RAM read fetches the new oldest timestamp. When an extreme leaves,
// the whole effective window (window_len clamped to 3 to DEPTH) is
// rescanned through the RAM read port at one entry a cycle. A finished
// result waits in the output register while the next beat is taken; the
// result after it is held back until that register drains. Writing the
// window length or dual channel register restarts the window.
module sliding_window_min_max_core import swmm_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int WORD = TIME_BITS + 2 * SAMPLE_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FINISH} state_t;

  state_t               state;
  logic [WLEN_BITS-1:0] window_len;
  logic                 dual;
  logic [CW-1:0]        held;
  logic [AW-1:0]        head;
  logic                 ready_flag;
  logic [TIME_BITS-1:0] oldest_time;
  logic [TIME_BITS-1:0] newest_time;
  logic [CW-1:0]        scan_cnt;
  logic [AW-1:0]        scan_addr;
  logic                 rd_valid;
  logic                 rd_first;
  logic                 rd_last;
  logic [AW-1:0]        rd_pos;

  logic [CW-1:0]        win_eff;
  logic                 accept;
  logic                 filling;
  logic                 cfg_hit;
  logic [AW-1:0]        slot;
  logic [AW-1:0]        head_next;
  logic [AW-1:0]        scan_addr_next;
  logic [CW-1:0]        held_next;
  logic [CW-1:0]        scan_len;
  logic                 any_stale;
  logic                 issue;

  logic [WORD-1:0]      wr_word;
  logic [WORD-1:0]      rd_word;
  logic [TIME_BITS-1:0] rd_time;
  sample_t              rd_a;
  sample_t              rd_b;

  trk_op_t              op_a;
  trk_op_t              op_b;
  sample_t              cand_a;
  sample_t              cand_b;
  logic [AW-1:0]        cand_pos;

  sample_t              min_a_val, max_a_val, min_b_val, max_b_val;
  logic [AW-1:0]        min_a_pos, max_a_pos, min_b_pos, max_b_pos;
  logic                 min_a_stale, max_a_stale, min_b_stale, max_b_stale;

  // Effective window length, clamped to the legal range
  always_comb begin
    if (32'(window_len) < WLEN_MIN) begin
      win_eff = CW'(WLEN_MIN);
    end else if (32'(window_len) > DEPTH) begin
      win_eff = CW'(DEPTH);
    end else begin
      win_eff = CW'(window_len);
    end
  end

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign filling   = (held < win_eff);
  assign cfg_hit   = cfg_we && ((cfg_index == REG_WINDOW_LEN) ||
                                (cfg_index == REG_DUAL_CHANNEL));
  assign held_next = held + CW'(1);

  // Ring buffer slots: new point goes to the next free slot while filling,
  // otherwise over the oldest one, which then advances
  assign slot      = filling ? held[AW-1:0] : head;
  assign head_next = ({1'b0, head} + (AW+1)'(1) == (AW+1)'(win_eff)) ?
                     '0 : head + AW'(1);
  assign scan_addr_next = ({1'b0, scan_addr} + (AW+1)'(1) == (AW+1)'(win_eff)) ?
                          '0 : scan_addr + AW'(1);

  // Rescan the whole window only if an extreme left it
  assign any_stale = min_a_stale | max_a_stale | min_b_stale | max_b_stale;
  assign scan_len  = any_stale ? win_eff : CW'(1);
  assign issue     = (state == ST_SCAN) && (scan_cnt < scan_len);

  // Point storage
  assign wr_word = {in_data.timestamp, in_data.sample_b, in_data.sample_a};
  assign rd_time = rd_word[WORD-1 -: TIME_BITS];
  assign rd_b    = rd_word[2*SAMPLE_BITS-1 -: SAMPLE_BITS];
  assign rd_a    = rd_word[SAMPLE_BITS-1:0];

  swmm_ram #(
    .WIDTH (WORD),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (slot),
    .wdata (wr_word),
    .raddr (scan_addr),
    .rdata (rd_word)
  );

  // Tracker operations
  always_comb begin
    op_a     = TRK_HOLD;
    op_b     = TRK_HOLD;
    cand_a   = rd_a;
    cand_b   = rd_b;
    cand_pos = rd_pos;
    if (cfg_hit) begin
      op_a = TRK_RESTART;
      op_b = TRK_RESTART;
    end else if (accept) begin
      cand_a   = in_data.sample_a;
      cand_b   = in_data.sample_b;
      cand_pos = slot;
      if (!filling) begin
        op_a = TRK_SLIDE;
      end else if (held == '0) begin
        op_a = TRK_LOAD;
      end else begin
        op_a = TRK_BETTER;
      end
      op_b = dual ? op_a : TRK_HOLD;
    end else if (rd_valid) begin
      op_a = rd_first ? TRK_SCAN_FIRST : TRK_SCAN_NEXT;
      op_b = op_a;
    end else if (state == ST_FINISH) begin
      op_a = TRK_SETTLE;
      op_b = TRK_SETTLE;
    end
  end

  swmm_extreme #(.AW(AW), .WANT_MAX(1'b0)) u_min_a (
    .clk (clk), .rst (rst), .op (op_a), .cand (cand_a), .cand_pos (cand_pos),
    .evict_pos (head), .val (min_a_val), .pos (min_a_pos), .stale (min_a_stale)
  );

  swmm_extreme #(.AW(AW), .WANT_MAX(1'b1)) u_max_a (
    .clk (clk), .rst (rst), .op (op_a), .cand (cand_a), .cand_pos (cand_pos),
    .evict_pos (head), .val (max_a_val), .pos (max_a_pos), .stale (max_a_stale)
  );

  swmm_extreme #(.AW(AW), .WANT_MAX(1'b0)) u_min_b (
    .clk (clk), .rst (rst), .op (op_b), .cand (cand_b), .cand_pos (cand_pos),
    .evict_pos (head), .val (min_b_val), .pos (min_b_pos), .stale (min_b_stale)
  );

  swmm_extreme #(.AW(AW), .WANT_MAX(1'b1)) u_max_b (
    .clk (clk), .rst (rst), .op (op_b), .cand (cand_b), .cand_pos (cand_pos),
    .evict_pos (head), .val (max_b_val), .pos (max_b_pos), .stale (max_b_stale)
  );

  // Sequencer, window state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      window_len <= WLEN_RESET;
      dual       <= 1'b1;
      held       <= '0;
      head       <= '0;
      ready_flag <= 1'b0;
      scan_cnt   <= '0;
      scan_addr  <= '0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_valid <= issue;
      rd_first <= (scan_cnt == '0);
      rd_last  <= (scan_cnt == scan_len - CW'(1));
      rd_pos   <= scan_addr;
      if (issue) begin
        scan_cnt  <= scan_cnt + CW'(1);
        scan_addr <= scan_addr_next;
      end

      if (out_valid && out_ready && (state != ST_FINISH)) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            newest_time <= in_data.timestamp;
            if (filling) begin
              if (held == '0) begin
                oldest_time <= in_data.timestamp;
              end
              held <= held_next;
              if (held_next > CW'(READY_ABOVE)) begin
                ready_flag <= 1'b1;
              end
              state <= ST_FINISH;
            end else begin
              head      <= head_next;
              scan_addr <= head_next;
              scan_cnt  <= '0;
              state     <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (rd_valid && rd_first) begin
            oldest_time <= rd_time;
          end
          if (rd_valid && rd_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid            <= 1'b1;
            out_data.min_a       <= min_a_val;
            out_data.max_a       <= max_a_val;
            out_data.min_b       <= dual ? min_b_val : '0;
            out_data.max_b       <= dual ? max_b_val : '0;
            out_data.oldest_time <= oldest_time;
            out_data.newest_time <= newest_time;
            out_data.fill_count  <= WLEN_BITS'(held);
            out_data.chart_ready <= ready_flag;
            state                <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      // Writes to the window length or dual channel register restart the window
      if (cfg_we) begin
        case (cfg_index)
          REG_WINDOW_LEN: begin
            window_len <= cfg_data;
            held       <= '0;
            head       <= '0;
            ready_flag <= 1'b0;
          end
          REG_DUAL_CHANNEL: begin
            dual       <= cfg_data[0];
            held       <= '0;
            head       <= '0;
            ready_flag <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### sv/swmm_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module swmm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/swmm_extreme.sv
// Tracker for one extreme (minimum or maximum) of one channel: cached value,
// its slot in the ring buffer and a pending rescan flag. Depends on swmm_pkg.
module swmm_extreme import swmm_pkg::*; #(
  parameter int AW       = 6,
  parameter bit WANT_MAX = 1'b0
) (
  input  logic          clk,
  input  logic          rst,
  input  trk_op_t       op,
  input  sample_t       cand,
  input  logic [AW-1:0] cand_pos,
  input  logic [AW-1:0] evict_pos,
  output sample_t       val,
  output logic [AW-1:0] pos,
  output logic          stale
);

  logic better;

  // Strict comparison: ties keep the earlier entry
  assign better = WANT_MAX ? (cand > val) : (cand < val);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      stale <= 1'b0;
    end else begin
      case (op)
        TRK_RESTART: begin
          pos   <= '0;
          stale <= 1'b0;
        end
        TRK_LOAD: begin
          val   <= cand;
          pos   <= cand_pos;
          stale <= 1'b0;
        end
        TRK_BETTER: begin
          if (better) begin
            val <= cand;
            pos <= cand_pos;
          end
        end
        TRK_SLIDE: begin
          if (pos == evict_pos) begin
            stale <= 1'b1;
          end else if (better) begin
            val <= cand;
            pos <= cand_pos;
          end
        end
        TRK_SCAN_FIRST: begin
          if (stale) begin
            val <= cand;
            pos <= cand_pos;
          end
        end
        TRK_SCAN_NEXT: begin
          if (stale && better) begin
            val <= cand;
            pos <= cand_pos;
          end
        end
        TRK_SETTLE: begin
          stale <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### dv/sliding_window_min_max_core_tb.sv
// Self-checking testbench for sliding_window_min_max_core: directed and random beats,
// checked against a cycle-free predictor of the window min/max. Needs swmm_pkg and the core.
`timescale 1ns / 100ps

module sliding_window_min_max_core_tb;
  import swmm_pkg::*;

  localparam int              WIN_DEPTH    = 64;
  localparam int              SETTLE_GAP   = WIN_DEPTH + 8;
  localparam int              MAX_REPORTS  = 100;
  localparam int              PHASE_COUNT  = 12;
  localparam int              PHASE_BEATS  = 68;
  localparam sample_t         SAMPLE_MAX   = 16'sh7FFF;
  localparam sample_t         SAMPLE_MIN   = 16'sh8000;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam int              REG_SPARE_LO = REG_DUAL_CHANNEL + 1;
  localparam int              REG_SPARE_HI = 2 ** CFG_INDEX_BITS - 1;
  localparam int              CH_A         = 0;
  localparam int              CH_B         = 1;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
  typedef enum int {VAL_FULL, VAL_TIES, VAL_EXTREME, VAL_RISING, VAL_FALLING} sample_pattern_t;

  // Window settings per random phase; entries not written in a phase are left as they were
  localparam logic [CFG_DATA_BITS-1:0] PHASE_WLEN [PHASE_COUNT] =
    '{7'd3, 7'd0, 7'd5, 7'd1, 7'd127, 7'd2, 7'd64, 7'd17, 7'd4, 7'd33, 7'd8, 7'd3};
  localparam logic [CFG_DATA_BITS-1:0] PHASE_DUAL [PHASE_COUNT] =
    '{7'd0, 7'd1, 7'd1, 7'd0, 7'd1, 7'd0, 7'd1, 7'd1, 7'd0, 7'd1, 7'd0, 7'd1};

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  in_item_t                  in_data = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  out_item_t                 out_data;
  logic                      cfg_we = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = REG_WINDOW_LEN;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  in_item_t    beats_to_send[$];
  out_item_t   window_summaries_due[$];
  in_item_t    last_queued = '0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned results_seen = 0;

  // Predictor state: window contents oldest first, tracked extreme slots
  logic [TIME_BITS-1:0] win_time [WIN_DEPTH];
  sample_t              chan_vals [2][WIN_DEPTH];
  int unsigned          win_count = 0;
  int unsigned          lo_pos [2] = '{0, 0};
  int unsigned          hi_pos [2] = '{0, 0};
  bit                   chart_seen = 1'b0;
  logic [WLEN_BITS-1:0] cur_wlen = WLEN_RESET;
  bit                   cur_dual = 1'b1;

  sliding_window_min_max_core #(
    .DEPTH(WIN_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit, well above the slowest legal run
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic int unsigned window_span();
    int unsigned w;
    w = 32'(cur_wlen);
    if (w < WLEN_MIN) w = WLEN_MIN;
    if (w > WIN_DEPTH) w = WIN_DEPTH;
    return w;
  endfunction

  function automatic bit beats_held(sample_t cand, sample_t held, bit want_max);
    return want_max ? (cand > held) : (cand < held);
  endfunction

  // Full window: the slot moves down with the shift; an evicted extreme forces a rescan
  function automatic int unsigned slide_extreme(int ch, int unsigned pos, int unsigned w,
                                                bit want_max);
    sample_t newest;
    newest = chan_vals[ch][w-1];
    if (pos > 0) begin
      pos--;
      if (beats_held(newest, chan_vals[ch][pos], want_max)) pos = w - 1;
      return pos;
    end
    // ties stay with the earliest slot
    for (int unsigned i = 1; i < w; i++) begin
      if (beats_held(chan_vals[ch][i], chan_vals[ch][pos], want_max)) pos = i;
    end
    return pos;
  endfunction

  function automatic void restart_window();
    win_count  = 0;
    lo_pos     = '{0, 0};
    hi_pos     = '{0, 0};
    chart_seen = 1'b0;
  endfunction

  function automatic void apply_register_write(logic [CFG_INDEX_BITS-1:0] idx,
                                               logic [CFG_DATA_BITS-1:0] value);
    case (idx)
      REG_WINDOW_LEN: begin
        cur_wlen = value[WLEN_BITS-1:0];
        restart_window();
      end
      REG_DUAL_CHANNEL: begin
        cur_dual = value[0];
        restart_window();
      end
      default: ;
    endcase
  endfunction

  function automatic out_item_t predict_window(in_item_t beat);
    int unsigned w;
    int unsigned slot;
    int unsigned chans;
    out_item_t   r;
    w     = window_span();
    chans = cur_dual ? 2 : 1;
    if (win_count < w) begin
      // still filling: newcomer takes over only if strictly better
      slot = win_count;
      if (slot == 0) begin
        lo_pos = '{0, 0};
        hi_pos = '{0, 0};
      end
      win_time[slot]        = beat.timestamp;
      chan_vals[CH_A][slot] = beat.sample_a;
      chan_vals[CH_B][slot] = beat.sample_b;
      for (int ch = 0; ch < chans; ch++) begin
        if (beats_held(chan_vals[ch][slot], chan_vals[ch][lo_pos[ch]], 1'b0)) lo_pos[ch] = slot;
        if (beats_held(chan_vals[ch][slot], chan_vals[ch][hi_pos[ch]], 1'b1)) hi_pos[ch] = slot;
      end
      win_count = slot + 1;
    end else begin
      for (int unsigned i = 0; i + 1 < w; i++) begin
        win_time[i]        = win_time[i+1];
        chan_vals[CH_A][i] = chan_vals[CH_A][i+1];
        chan_vals[CH_B][i] = chan_vals[CH_B][i+1];
      end
      win_time[w-1]        = beat.timestamp;
      chan_vals[CH_A][w-1] = beat.sample_a;
      chan_vals[CH_B][w-1] = beat.sample_b;
      for (int ch = 0; ch < chans; ch++) begin
        lo_pos[ch] = slide_extreme(ch, lo_pos[ch], w, 1'b0);
        hi_pos[ch] = slide_extreme(ch, hi_pos[ch], w, 1'b1);
      end
    end
    if (win_count > READY_ABOVE) chart_seen = 1'b1;

    r.min_a       = chan_vals[CH_A][lo_pos[CH_A]];
    r.max_a       = chan_vals[CH_A][hi_pos[CH_A]];
    r.min_b       = cur_dual ? chan_vals[CH_B][lo_pos[CH_B]] : '0;
    r.max_b       = cur_dual ? chan_vals[CH_B][hi_pos[CH_B]] : '0;
    r.oldest_time = win_time[0];
    r.newest_time = win_time[win_count-1];
    r.fill_count  = win_count[WLEN_BITS-1:0];
    r.chart_ready = chart_seen;
    return r;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        window_summaries_due.push_back(predict_window(in_data));
      end
      if (!in_valid || in_ready) begin
        if (beats_to_send.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= beats_to_send.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor
  task automatic report_mismatch(string what);
    if (error_count < MAX_REPORTS) $display("ERROR %0t ns: result %0d: %s", $time, results_seen, what);
    error_count++;
  endtask

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (window_summaries_due.size() == 0) begin
          report_mismatch("result beat with nothing outstanding");
        end else begin
          want = window_summaries_due.pop_front();
          if (out_data.min_a !== want.min_a)
            report_mismatch($sformatf("min_a %0d, want %0d", out_data.min_a, want.min_a));
          if (out_data.max_a !== want.max_a)
            report_mismatch($sformatf("max_a %0d, want %0d", out_data.max_a, want.max_a));
          if (out_data.min_b !== want.min_b)
            report_mismatch($sformatf("min_b %0d, want %0d", out_data.min_b, want.min_b));
          if (out_data.max_b !== want.max_b)
            report_mismatch($sformatf("max_b %0d, want %0d", out_data.max_b, want.max_b));
          if (out_data.oldest_time !== want.oldest_time)
            report_mismatch($sformatf("oldest_time %h, want %h",
                                      out_data.oldest_time, want.oldest_time));
          if (out_data.newest_time !== want.newest_time)
            report_mismatch($sformatf("newest_time %h, want %h",
                                      out_data.newest_time, want.newest_time));
          if (out_data.fill_count !== want.fill_count)
            report_mismatch($sformatf("fill_count %0d, want %0d",
                                      out_data.fill_count, want.fill_count));
          if (out_data.chart_ready !== want.chart_ready)
            report_mismatch($sformatf("chart_ready %b, want %b",
                                      out_data.chart_ready, want.chart_ready));
        end
        results_seen++;
      end
      out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus helpers
  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_SENDER:   begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
      IDLE_RECEIVER: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
      IDLE_BOTH:     begin sender_idle_pct = 6;  receiver_stall_pct = 6;  end
      default:       begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
    endcase
  endtask

  task automatic queue_beat(logic [TIME_BITS-1:0] ts, sample_t a, sample_t b);
    in_item_t beat;
    beat.timestamp = ts;
    beat.sample_a  = a;
    beat.sample_b  = b;
    beats_to_send.push_back(beat);
    last_queued = beat;
  endtask

  // Block is idle once every beat is in and every result is out
  task automatic wait_for_drain();
    while (beats_to_send.size() != 0 || in_valid || window_summaries_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    apply_register_write(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic sample_t next_sample(sample_pattern_t pat, sample_t prev);
    case (pat)
      VAL_FULL:    return sample_t'($urandom);
      VAL_TIES:    return sample_t'($urandom_range(0, 6)) - 16'sd3;
      VAL_EXTREME: return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      VAL_RISING:  return prev + sample_t'($urandom_range(1, 400));
      default:     return prev - sample_t'($urandom_range(1, 400));
    endcase
  endfunction

  // Bursts of eight beats share a value pattern per channel: ramps force rescans,
  // narrow ranges force ties
  task automatic queue_random_beats(int unsigned count);
    sample_pattern_t      pat_a;
    sample_pattern_t      pat_b;
    logic [TIME_BITS-1:0] ts;
    pat_a = VAL_FULL;
    pat_b = VAL_FULL;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 8 == 0) begin
        pat_a = sample_pattern_t'($urandom_range(VAL_FULL, VAL_FALLING));
        pat_b = sample_pattern_t'($urandom_range(VAL_FULL, VAL_FALLING));
      end
      if ($urandom_range(0, 7) == 0) ts = TIME_BITS'({$urandom, $urandom});
      else ts = last_queued.timestamp + TIME_BITS'($urandom_range(1, 1000));
      queue_beat(ts, next_sample(pat_a, last_queued.sample_a),
                 next_sample(pat_b, last_queued.sample_b));
    end
  endtask

  // ---------------------------------------------------------------- test sequence
  initial begin : stimulus
    logic [TIME_BITS-1:0] ts;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_idle(IDLE_NONE);

    // reset settings: 64-point window, both channels; sample and time extremes
    queue_beat('0, SAMPLE_MAX, SAMPLE_MIN);
    queue_beat(TIME_MAX, SAMPLE_MIN, SAMPLE_MAX);
    queue_beat(48'd1, 16'sd0, 16'sd0);
    queue_beat(48'd2, -16'sd1, 16'sd1);
    wait_for_drain();

    // shortest window: every beat past the third slides it
    write_register(REG_WINDOW_LEN, CFG_DATA_BITS'(WLEN_MIN));
    ts = 48'd10;
    // rising A and falling B: the evicted extreme is always the oldest, so rescans
    for (int k = 1; k <= 4; k++) begin
      queue_beat(ts, sample_t'(100 * k), sample_t'(-100 * k));
      ts++;
    end
    // equal values: rescans must keep the earliest slot
    repeat (4) begin
      queue_beat(ts, 16'sd50, 16'sd50);
      ts++;
    end
    queue_beat(ts, SAMPLE_MAX, SAMPLE_MIN);
    queue_beat(ts + 1, SAMPLE_MIN, SAMPLE_MAX);
    repeat (3) queue_beat(ts + 2, 16'sd0, 16'sd0);
    queue_beat(TIME_MAX - 1, -16'sd5, 16'sd5);
    queue_beat(TIME_MAX, -16'sd5, 16'sd5);
    wait_for_drain();

    // random phases; each one restarts the window through one or both registers
    for (int p = 0; p < PHASE_COUNT; p++) begin
      set_idle(idle_mode_t'(p % 4));
      if (p % 3 != 2) write_register(REG_WINDOW_LEN, PHASE_WLEN[p]);
      if (p % 3 != 1) write_register(REG_DUAL_CHANNEL, PHASE_DUAL[p]);
      queue_random_beats(PHASE_BEATS / 2);
      wait_for_drain();
      // unmapped index mid-window: must leave the window untouched
      write_register(CFG_INDEX_BITS'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                     CFG_DATA_BITS'($urandom));
      queue_random_beats(PHASE_BEATS - PHASE_BEATS / 2);
      wait_for_drain();
    end

    set_idle(IDLE_NONE);
    wait_for_drain();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
sv/swmm_pkg.sv
sv/swmm_ram.sv
sv/swmm_extreme.sv
sv/sliding_window_min_max_core.sv
dv/sliding_window_min_max_core_tb.sv
